@@ hw/rtl/scsa_pkg.sv @@
package scsa_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_BIG  = 3'd1,
        ST_EXHAUST  = 3'd2,
        ST_CORRUPT  = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_META     = 3'd5,
        ST_UNOWNED  = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP_RD,
        S_POP_WR,
        S_CLAIM,
        S_BUILD,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } state_t;

    localparam int unsigned PAGE_BYTES = 4096;
    localparam logic [3:0] UNOWNED = 4'd8;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic meta_rd;    // read page metadata at scan/free page
        logic scan_inc;   // advance scan pointer
        logic link_rd;    // read link of current head
        logic pop_wr;     // update page after pop
        logic claim_wr;   // claim new page
        logic build_wr;   // write one link of the new page
        logic free_wr;    // push freed slot
        logic set_res;    // latch result
        status_t res_st;
        logic clear_ptr;  // reset scan/build pointers
    } cmd_bus_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_free;
        logic too_big;
        logic scan_end;
        logic pool_full;
        logic page_match;
        logic head_bad;
        logic build_end;
        logic f_unowned;
        logic f_empty;
        logic f_meta;
    } stat_bus_t;

    // block size in bytes of a class: 8 shifted left by the class
    function automatic logic [10:0] blk_size(input logic [2:0] c);
        blk_size = 11'd8 << c;
    endfunction

endpackage

@@ hw/rtl/scsa_ctrl.sv @@
module scsa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  scsa_pkg::stat_bus_t st,
    output scsa_pkg::cmd_bus_t  cmd
);

    scsa_pkg::state_t state_reg, state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scsa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.res_st = scsa_pkg::ST_OK;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            scsa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.clear_ptr = 1'b1;
                    state_next = scsa_pkg::S_SCAN_RD;
                end
            end
            scsa_pkg::S_SCAN_RD:
            begin
                if (st.is_free)
                begin
                    cmd.meta_rd = 1'b1;
                    state_next = scsa_pkg::S_FREE_RD;
                end
                else if (st.too_big)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_st = scsa_pkg::ST_TOO_BIG;
                    state_next = scsa_pkg::S_DONE;
                end
                else if (st.scan_end)
                begin
                    if (st.pool_full)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_st = scsa_pkg::ST_EXHAUST;
                        state_next = scsa_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = scsa_pkg::S_CLAIM;
                    end
                end
                else
                begin
                    cmd.meta_rd = 1'b1;
                    state_next = scsa_pkg::S_SCAN_CHK;
                end
            end
            scsa_pkg::S_SCAN_CHK:
            begin
                if (!st.page_match)
                begin
                    cmd.scan_inc = 1'b1;
                    state_next = scsa_pkg::S_SCAN_RD;
                end
                else if (st.head_bad)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_st = scsa_pkg::ST_CORRUPT;
                    state_next = scsa_pkg::S_DONE;
                end
                else
                begin
                    cmd.link_rd = 1'b1;
                    state_next = scsa_pkg::S_POP_RD;
                end
            end
            scsa_pkg::S_POP_RD:
            begin
                state_next = scsa_pkg::S_POP_WR;
            end
            scsa_pkg::S_POP_WR:
            begin
                cmd.pop_wr = 1'b1;
                cmd.set_res = 1'b1;
                state_next = scsa_pkg::S_DONE;
            end
            scsa_pkg::S_CLAIM:
            begin
                cmd.claim_wr = 1'b1;
                cmd.set_res = 1'b1;
                state_next = scsa_pkg::S_BUILD;
            end
            scsa_pkg::S_BUILD:
            begin
                if (st.build_end)
                begin
                    state_next = scsa_pkg::S_DONE;
                end
                else
                begin
                    cmd.build_wr = 1'b1;
                end
            end
            scsa_pkg::S_FREE_RD:
            begin
                state_next = scsa_pkg::S_FREE_CHK;
            end
            scsa_pkg::S_FREE_CHK:
            begin
                cmd.set_res = 1'b1;
                state_next = scsa_pkg::S_DONE;
                priority if (st.f_unowned)
                begin
                    cmd.res_st = scsa_pkg::ST_UNOWNED;
                end
                else if (st.f_empty)
                begin
                    cmd.res_st = scsa_pkg::ST_EMPTY;
                end
                else if (st.f_meta)
                begin
                    cmd.res_st = scsa_pkg::ST_META;
                end
                else
                begin
                    cmd.free_wr = 1'b1;
                end
            end
            scsa_pkg::S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = scsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scsa_pkg::S_IDLE;
            end
        endcase
    end

    // only one memory write per cycle
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.pop_wr, cmd.claim_wr, cmd.build_wr, cmd.free_wr}) <= 1)
        else $error("multiple writes");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("accept while result pending");
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");

endmodule

@@ hw/rtl/scsa_dp.sv @@
module scsa_dp
#(
    parameter int NUM_PAGES    = 64,
    parameter int HEADER_BYTES = 64,
    parameter int NUM_CLASSES  = 8,
    parameter int MAX_SLOTS    = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               command,
    input  logic [11:0]        request_size,
    input  logic [17:0]        free_address,
    input  scsa_pkg::cmd_bus_t  cmd,
    output scsa_pkg::stat_bus_t st,
    output logic [2:0]         status,
    output logic [17:0]        block_address,
    output logic [2:0]         size_class
);

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int SW = $clog2(MAX_SLOTS);

    // per-class geometry: round the header up to the block size
    function automatic logic [12:0] area_start(input logic [2:0] c);
        int sh;
        sh = int'(c) + 3;
        area_start = 13'(((HEADER_BYTES + (1 << sh) - 1) >> sh) << sh);
    endfunction

    function automatic logic [9:0] slot_count(input logic [2:0] c);
        int s;
        int n;
        s = int'(area_start(c));
        n = (s >= 4096) ? 0 : (4096 - s) >> (c + 3);
        slot_count = 10'((n > MAX_SLOTS) ? MAX_SLOTS : n);
    endfunction

    // page metadata memory: owner, used count, head
    logic [3:0]    owner_mem [NUM_PAGES];
    logic [9:0]    used_mem  [NUM_PAGES];
    logic [SW-1:0] head_mem  [NUM_PAGES];
    logic [NUM_PAGES-1:0] claimed_reg;
    logic [SW-1:0] link_mem  [NUM_PAGES*MAX_SLOTS];

    logic          cmd_reg;
    logic [17:0]   faddr_reg;
    logic [2:0]    cls_reg;
    logic          big_reg;
    logic [CW-1:0] scan_reg;
    logic [CW-1:0] claimed_cnt_reg;
    logic [SW:0]   bld_reg;
    logic [3:0]    rd_owner_reg;
    logic [9:0]    rd_used_reg;
    logic [SW-1:0] rd_head_reg;
    logic          rd_valid_reg;
    logic [SW-1:0] rd_link_reg;
    logic [2:0]    status_reg;
    logic [17:0]   addr_reg;
    logic [2:0]    cls_out_reg;

    logic [2:0]    cls_next;
    logic          big_next;
    logic [PW-1:0] page_sel;
    logic [5:0]    fpage_hi;
    logic          fpage_oob;
    logic [11:0]   foff;
    logic [2:0]    fcls;
    logic [12:0]   fst;
    logic [11:0]   fidx;
    logic [9:0]    slots_c;
    logic [PW-1:0] new_page;
    logic [PW-1:0] scan_page;

    // pick first fitting class
    always_comb
    begin
        cls_next = 3'd0;
        big_next = 1'b1;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (12'(scsa_pkg::blk_size(3'(c))) >= request_size
                || (c == 7 && request_size <= 12'd1024))
            begin
                cls_next = 3'(c);
                big_next = 1'b0;
            end
        end
    end

    assign scan_page = scan_reg[PW-1:0];
    assign new_page  = claimed_cnt_reg[PW-1:0];
    assign fpage_hi  = faddr_reg[17:12];
    assign fpage_oob = (32'(fpage_hi) >= NUM_PAGES);
    assign page_sel  = cmd_reg ? PW'(fpage_hi) : scan_page;
    assign foff      = faddr_reg[11:0];
    assign fcls      = rd_owner_reg[2:0];
    assign fst       = area_start(fcls);
    assign fidx      = 12'((13'(foff) - fst) >> ({1'b0, fcls} + 4'd3));
    assign slots_c   = slot_count(cls_reg);

    // status to controller
    always_comb
    begin
        st.is_free    = cmd_reg;
        st.too_big    = big_reg;
        st.scan_end   = (scan_reg >= claimed_cnt_reg);
        st.pool_full  = (32'(claimed_cnt_reg) >= NUM_PAGES);
        st.page_match = rd_valid_reg && (rd_owner_reg == {1'b0, cls_reg})
                        && (rd_used_reg < slots_c);
        st.head_bad   = (10'(rd_head_reg) >= slots_c);
        st.build_end  = (10'(bld_reg) >= slots_c);
        st.f_unowned  = fpage_oob || !rd_valid_reg || rd_owner_reg[3];
        st.f_empty    = (rd_used_reg == 10'd0);
        st.f_meta     = (32'(foff) < HEADER_BYTES) || (13'(foff) < fst)
                        || (10'(fidx) >= slot_count(fcls)) || (fidx[11:10] != 2'd0);
    end

    // claim flags and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claimed_reg     <= '0;
            claimed_cnt_reg <= '0;
        end
        else if (cmd.claim_wr)
        begin
            claimed_reg[new_page] <= 1'b1;
            claimed_cnt_reg       <= claimed_cnt_reg + 1'b1;
        end
    end

    // capture item, pointers, result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            faddr_reg <= free_address;
            cls_reg   <= cls_next;
            big_reg   <= big_next;
        end
        if (cmd.clear_ptr)
        begin
            scan_reg <= '0;
            bld_reg  <= (SW+1)'(1);
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.build_wr)
        begin
            bld_reg <= bld_reg + 1'b1;
        end
        if (cmd.set_res)
        begin
            status_reg  <= cmd.res_st;
            addr_reg    <= 18'd0;
            cls_out_reg <= cls_reg;
            if (cmd.res_st == scsa_pkg::ST_TOO_BIG || cmd.res_st == scsa_pkg::ST_UNOWNED)
            begin
                cls_out_reg <= 3'd0;
            end
            if (cmd_reg)
            begin
                if (!(cmd.res_st == scsa_pkg::ST_UNOWNED))
                begin
                    cls_out_reg <= fcls;
                end
            end
            else if (cmd.pop_wr)
            begin
                addr_reg <= 18'({scan_page, 12'd0}) + 18'(area_start(cls_reg))
                            + 18'(18'(rd_head_reg) << ({1'b0, cls_reg} + 4'd3));
            end
            else if (cmd.claim_wr)
            begin
                addr_reg <= 18'({new_page, 12'd0}) + 18'(area_start(cls_reg));
            end
        end
    end

    // metadata memory read
    always_ff @(posedge clk)
    begin
        if (cmd.meta_rd)
        begin
            rd_owner_reg <= owner_mem[page_sel];
            rd_used_reg  <= used_mem[page_sel];
            rd_head_reg  <= head_mem[page_sel];
            rd_valid_reg <= claimed_reg[page_sel];
        end
    end

    // metadata memory write
    always_ff @(posedge clk)
    begin
        if (cmd.claim_wr)
        begin
            owner_mem[new_page] <= {1'b0, cls_reg};
            used_mem[new_page]  <= 10'd1;
            head_mem[new_page]  <= SW'(1);
        end
        else if (cmd.pop_wr)
        begin
            used_mem[scan_page] <= rd_used_reg + 10'd1;
            head_mem[scan_page] <= rd_link_reg;
        end
        else if (cmd.free_wr)
        begin
            used_mem[page_sel] <= rd_used_reg - 10'd1;
            head_mem[page_sel] <= SW'(fidx);
        end
    end

    // link memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.build_wr)
        begin
            link_mem[{new_page - PW'(1), bld_reg[SW-1:0]}] <= SW'(bld_reg + 1'b1);
        end
        else if (cmd.free_wr)
        begin
            link_mem[{page_sel, SW'(fidx)}] <= rd_head_reg;
        end
        if (cmd.link_rd)
        begin
            rd_link_reg <= link_mem[{scan_page, rd_head_reg}];
        end
    end

    assign status        = status_reg;
    assign block_address = addr_reg;
    assign size_class    = cls_out_reg;

    a_claim_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim_wr |-> (32'(claimed_cnt_reg) < NUM_PAGES))
        else $error("claim beyond pool");
    a_pop_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link_rd |-> (st.page_match && !st.head_bad))
        else $error("pop on wrong page");
    a_free_owned: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_wr |-> !st.f_unowned)
        else $error("free into unowned page");

endmodule

@@ hw/rtl/size_class_slab_allocator.sv @@
// channel | signals                                     | direction
// input   | in_valid in_ready command request_size free_address | to block
// output  | out_valid out_ready status block_address size_class | from block
//
// One item at a time. A free reads and checks one page's metadata; an allocate
// checks each claimed page it scans, and on claiming a new page builds its link
// chain one entry a cycle through the single write port of the link memory.
// rst_n clears control and the claimed-page flags at once; links need no clear.
// A result waits in its register until out_ready; no input is taken meanwhile.
module size_class_slab_allocator
#(
    parameter int NUM_PAGES    = 64,
    parameter int HEADER_BYTES = 64,
    parameter int NUM_CLASSES  = 8,
    parameter int MAX_SLOTS    = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [11:0] request_size,
    input  logic [17:0] free_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [17:0] block_address,
    output logic [2:0]  size_class
);

    scsa_pkg::cmd_bus_t  cmd;
    scsa_pkg::stat_bus_t st;

    scsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    scsa_dp
    #(
        .NUM_PAGES    (NUM_PAGES),
        .HEADER_BYTES (HEADER_BYTES),
        .NUM_CLASSES  (NUM_CLASSES),
        .MAX_SLOTS    (MAX_SLOTS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (command),
        .request_size  (request_size),
        .free_address  (free_address),
        .cmd           (cmd),
        .st            (st),
        .status        (status),
        .block_address (block_address),
        .size_class    (size_class)
    );

endmodule

@@ tb/sv/size_class_slab_allocator_tb.sv @@
`timescale 1ns / 1ps

module size_class_slab_allocator_tb;

    localparam int N_PAGES   = 64;
    localparam int HDR_BYTES = 64;
    localparam int N_CLASSES = 8;
    localparam int SLOT_CAP  = 512;
    localparam int N_RANDOM  = 700;
    localparam int N_CALM    = 80;

    typedef struct packed {
        scsa_pkg::cmd_t cmd;
        logic [11:0]    req_size;
        logic [17:0]    addr;
    } alloc_req_t;

    typedef struct packed {
        scsa_pkg::status_t st;
        logic [17:0]       blk_addr;
        logic [2:0]        cls;
    } alloc_resp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [11:0] request_size;
    logic [17:0] free_address;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [17:0] block_address;
    logic [2:0]  size_class;

    // predictor state
    logic [3:0]  pg_class [N_PAGES];
    logic [8:0]  pg_used  [N_PAGES];
    logic [8:0]  pg_head  [N_PAGES];
    logic [8:0]  free_link [N_PAGES*SLOT_CAP];
    int          n_claimed;

    alloc_req_t  req_q [$];
    alloc_resp_t resp_q [$];
    logic [17:0] live_blocks [$];

    int  n_errors;
    int  n_accepted;
    int  status_seen [8];
    bit  in_xfer;
    bit  calm;
    bit  long_hold;
    int  send_gap;
    int  recv_gap;

    size_class_slab_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .request_size  (request_size),
        .free_address  (free_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .block_address (block_address),
        .size_class    (size_class)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int block_bytes(input int c);
        return 8 << c;
    endfunction

    function automatic int slot_base(input int c);
        int b;
        b = block_bytes(c);
        return (HDR_BYTES + b - 1) / b * b;
    endfunction

    function automatic int slots_per_page(input int c);
        int n;
        n = (slot_base(c) >= 4096) ? 0 : (4096 - slot_base(c)) / block_bytes(c);
        return (n > SLOT_CAP) ? SLOT_CAP : n;
    endfunction

    // compute the allocator response and advance the page state
    function automatic alloc_resp_t slab_response(input alloc_req_t r);
        alloc_resp_t res;
        int c, p, h, nslots, off, idx;
        res = '{st: scsa_pkg::ST_OK, blk_addr: '0, cls: '0};
        if (r.cmd == scsa_pkg::CMD_ALLOC)
        begin
            for (c = 0; c < N_CLASSES; c++)
                if (block_bytes(c) >= r.req_size)
                    break;
            if (c >= N_CLASSES)
            begin
                res.st = scsa_pkg::ST_TOO_BIG;
                return res;
            end
            res.cls = c[2:0];
            nslots = slots_per_page(c);
            for (p = 0; p < n_claimed; p++)
            begin
                if (pg_class[p] != c || pg_used[p] >= nslots)
                    continue;
                h = pg_head[p];
                if (h >= nslots)
                begin
                    res.st = scsa_pkg::ST_CORRUPT;
                    return res;
                end
                res.blk_addr = 18'(p * 4096 + slot_base(c) + h * block_bytes(c));
                pg_head[p] = free_link[p*SLOT_CAP + h];
                pg_used[p] = pg_used[p] + 9'd1;
                return res;
            end
            if (n_claimed >= N_PAGES)
            begin
                res.st = scsa_pkg::ST_EXHAUST;
                return res;
            end
            p = n_claimed;
            n_claimed++;
            pg_class[p] = c[3:0];
            pg_used[p] = 9'd1;
            pg_head[p] = 9'd1;
            for (int i = 1; i < nslots; i++)
                free_link[p*SLOT_CAP + i] = 9'(i + 1);
            res.blk_addr = 18'(p * 4096 + slot_base(c));
            return res;
        end
        p = r.addr[17:12];
        off = r.addr[11:0];
        if (pg_class[p] == scsa_pkg::UNOWNED)
        begin
            res.st = scsa_pkg::ST_UNOWNED;
            return res;
        end
        c = pg_class[p];
        res.cls = c[2:0];
        if (pg_used[p] == 0)
        begin
            res.st = scsa_pkg::ST_EMPTY;
            return res;
        end
        if (off < HDR_BYTES || off < slot_base(c))
        begin
            res.st = scsa_pkg::ST_META;
            return res;
        end
        idx = (off - slot_base(c)) / block_bytes(c);
        if (idx >= slots_per_page(c))
        begin
            res.st = scsa_pkg::ST_META;
            return res;
        end
        free_link[p*SLOT_CAP + idx] = pg_head[p];
        pg_used[p] = pg_used[p] - 9'd1;
        pg_head[p] = idx[8:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        n_errors++;
    endtask

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        alloc_req_t  r;
        alloc_resp_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                r = '{cmd: scsa_pkg::cmd_t'(command), req_size: request_size,
                      addr: free_address};
                resp_q.push_back(slab_response(r));
                in_xfer = 1'b1;
                n_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (resp_q.size() == 0)
                begin
                    report_mismatch("unexpected result, status", status, 0);
                end
                else
                begin
                    e = resp_q.pop_front();
                    if (status != e.st)
                        report_mismatch("status", status, e.st);
                    if (block_address != e.blk_addr)
                        report_mismatch("block_address", block_address, e.blk_addr);
                    if (size_class != e.cls)
                        report_mismatch("size_class", size_class, e.cls);
                    status_seen[e.st]++;
                    if (e.st == scsa_pkg::ST_OK && e.blk_addr != 0)
                        live_blocks.push_back(e.blk_addr);
                end
            end
        end
    end

    // driver: hold the item until transfer, then advance with random gaps
    always @(negedge clk)
    begin
        alloc_req_t r;
        if (rst_n && (!in_valid || in_xfer))
        begin
            in_xfer = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                r = req_q.pop_front();
                command      <= r.cmd;
                request_size <= r.req_size;
                free_address <= r.addr;
                in_valid     <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // long receiver stall once the pool is partly used
    initial
    begin
        long_hold = 1'b0;
        wait (n_accepted >= 150);
        @(negedge clk);
        long_hold = 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic queue_req(input scsa_pkg::cmd_t cmd, input int sz, input int addr);
        while (req_q.size() >= 2)
            @(posedge clk);
        req_q.push_back('{cmd: cmd, req_size: 12'(sz), addr: 18'(addr)});
    endtask

    // pick a free target: a live block, a random address, or a page offset
    function automatic int free_target();
        int k, a;
        k = $urandom_range(0, 9);
        if (k < 6 && live_blocks.size() > 0)
        begin
            a = $urandom_range(0, live_blocks.size() - 1);
            k = live_blocks[a];
            live_blocks.delete(a);
            // sometimes free off the slot start
            if ($urandom_range(0, 7) == 0)
                k = k + $urandom_range(1, 7);
            return k;
        end
        if (k < 8)
            return $urandom_range(0, 262143);
        return $urandom_range(0, (n_claimed > 0) ? n_claimed : 1) * 4096
            + $urandom_range(0, 4095);
    endfunction

    initial
    begin
        int sizes [13] = '{0, 1, 8, 9, 16, 17, 32, 64, 128, 256, 512, 1024, 1025};
        int k;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        command      = 1'b0;
        request_size = '0;
        free_address = '0;
        n_errors     = 0;
        n_accepted   = 0;
        n_claimed    = 0;
        in_xfer      = 1'b0;
        calm         = 1'b0;
        send_gap     = 0;
        recv_gap     = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        for (int p = 0; p < N_PAGES; p++)
        begin
            pg_class[p] = scsa_pkg::UNOWNED;
            pg_used[p]  = '0;
            pg_head[p]  = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every class, zero and oversize requests
        foreach (sizes[i])
            queue_req(scsa_pkg::CMD_ALLOC, sizes[i], 0);
        queue_req(scsa_pkg::CMD_ALLOC, 4095, 0);
        // page 0 is class 0, page 1 is class 1
        queue_req(scsa_pkg::CMD_FREE, 0, 64);
        queue_req(scsa_pkg::CMD_FREE, 0, 65);
        queue_req(scsa_pkg::CMD_FREE, 0, 0);
        queue_req(scsa_pkg::CMD_FREE, 0, 63);
        queue_req(scsa_pkg::CMD_FREE, 0, 4096 + 1024);
        queue_req(scsa_pkg::CMD_FREE, 0, 4096 + 1024);
        queue_req(scsa_pkg::CMD_FREE, 0, 262143);
        queue_req(scsa_pkg::CMD_FREE, 0, 4096 + 100);
        queue_req(scsa_pkg::CMD_ALLOC, 1000, 0);
        while (req_q.size() > 0 || in_valid)
            @(posedge clk);
        live_blocks.delete();

        // random: a fill phase biased to large classes, then a mixed phase
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n >= N_RANDOM - N_CALM)
                calm = 1'b1;
            k = $urandom_range(0, 9);
            if ((n < 300 && k < 8) || (n >= 300 && k < 5))
            begin
                k = $urandom_range(0, 9);
                if (k < 5)
                    queue_req(scsa_pkg::CMD_ALLOC, $urandom_range(257, 1024), 0);
                else if (k < 8)
                    queue_req(scsa_pkg::CMD_ALLOC, $urandom_range(0, 256), 0);
                else
                    queue_req(scsa_pkg::CMD_ALLOC, $urandom_range(0, 4095), 0);
            end
            else
            begin
                queue_req(scsa_pkg::CMD_FREE, $urandom_range(0, 4095), free_target());
            end
        end

        while (req_q.size() > 0 || in_valid)
            @(posedge clk);
        while (resp_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (resp_q.size() > 0)
            report_mismatch("results still pending", resp_q.size(), 0);

        $display("items %0d, pages claimed %0d, ok %0d, too big %0d, exhausted %0d",
            n_accepted, n_claimed, status_seen[scsa_pkg::ST_OK],
            status_seen[scsa_pkg::ST_TOO_BIG], status_seen[scsa_pkg::ST_EXHAUST]);
        $display("corrupt %0d, empty %0d, metadata %0d, unowned %0d, mismatches %0d",
            status_seen[scsa_pkg::ST_CORRUPT], status_seen[scsa_pkg::ST_EMPTY],
            status_seen[scsa_pkg::ST_META], status_seen[scsa_pkg::ST_UNOWNED], n_errors);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/scsa_pkg.sv
hw/rtl/scsa_ctrl.sv
hw/rtl/scsa_dp.sv
hw/rtl/size_class_slab_allocator.sv
tb/sv/size_class_slab_allocator_tb.sv
